### sv/pcwrl_pkg.sv
// shared types, constants and codes for the per-client window rate limiter
// no dependencies; every other file depends on this package
`default_nettype none

package pcwrl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	// field widths
	localparam int KEY_W  = 64;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 16;
	localparam int REM_W  = 20;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 16;

	// apb port geometry
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// fixed constants of the algorithm
	localparam logic [TIME_W-1:0] PURGE_INTERVAL  = TIME_W'(300);
	localparam logic [REM_W-1:0]  LOOPBACK_FACTOR = REM_W'(10);

	// register indexes
	localparam logic REG_MAX_REQUESTS = 1'b0;
	localparam logic REG_WINDOW_LEN   = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] MAX_REQUESTS_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST   = CFG_W'(60);

	// action codes
	localparam logic ACT_CHECK = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_LIMITED    = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_TABLE_FULL = 2'd2;

	// configuration seen by the datapath
	typedef struct packed {
		logic [CFG_W-1:0] max_requests;
		logic [CFG_W-1:0] window_len;
	} pcwrl_cfg_t;

	// one input item
	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  client_key;
		logic              is_loopback;
		logic [TIME_W-1:0] now_seconds;
	} pcwrl_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic purge;
		logic match;
		logic eval;
		logic finish;
	} pcwrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} pcwrl_stat_t;

endpackage

`default_nettype wire

### sv/pcwrl_in_if.sv
// input channel: valid/ready handshake with one request item as payload
// depends on pcwrl_pkg for field widths
`default_nettype none

interface pcwrl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [pcwrl_pkg::KEY_W-1:0]  client_key;
	logic                        is_loopback;
	logic [pcwrl_pkg::TIME_W-1:0] now_seconds;

	modport source(output valid, action, client_key, is_loopback, now_seconds,
		input ready);
	modport sink(input valid, action, client_key, is_loopback, now_seconds,
		output ready);
endinterface

`default_nettype wire

### sv/pcwrl_out_if.sv
// output channel: valid/ready handshake with one result item as payload
// depends on pcwrl_pkg for field widths
`default_nettype none

interface pcwrl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        allowed;
	logic [pcwrl_pkg::STAT_W-1:0] status;
	logic [pcwrl_pkg::CNT_W-1:0]  made_count;
	logic [pcwrl_pkg::REM_W-1:0]  left_count;
	logic [pcwrl_pkg::CFG_W-1:0]  reset_seconds;
	logic [pcwrl_pkg::CFG_W-1:0]  limit_value;

	modport source(output valid, allowed, status, made_count, left_count,
		reset_seconds, limit_value, input ready);
	modport sink(input valid, allowed, status, made_count, left_count,
		reset_seconds, limit_value, output ready);
endinterface

`default_nettype wire

### sv/pcwrl_regs.sv
// apb configuration registers: max_requests and window length
// depends on pcwrl_pkg
`default_nettype none

module pcwrl_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pcwrl_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pcwrl_pkg::DATA_W-1:0] pwdata,
	output logic      [pcwrl_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	output pcwrl_pkg::pcwrl_cfg_t             cfg
);
	import pcwrl_pkg::*;

	logic             wr_en;
	logic             reg_sel;
	logic [CFG_W-1:0] max_requests_q;
	logic [CFG_W-1:0] window_len_q;

	// register index is the word address
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_requests_q <= MAX_REQUESTS_RST;
			window_len_q   <= WINDOW_LEN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_REQUESTS: max_requests_q <= pwdata[CFG_W-1:0];
				REG_WINDOW_LEN:   window_len_q   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_MAX_REQUESTS: prdata = DATA_W'(max_requests_q);
			REG_WINDOW_LEN:   prdata = DATA_W'(window_len_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.max_requests = max_requests_q;
	assign cfg.window_len   = window_len_q;

endmodule

`default_nettype wire

### sv/pcwrl_ctrl.sv
// controller state machine: steps one item through purge, match, read, eval, done
// depends on pcwrl_pkg for the command and status structs
`default_nettype none

module pcwrl_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire pcwrl_pkg::pcwrl_stat_t stat,
	output pcwrl_pkg::pcwrl_cmd_t      cmd
);
	import pcwrl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PURGE = 3'd1;
	localparam logic [2:0] ST_MATCH = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_PURGE;
			ST_PURGE: state_d = ST_MATCH;
			ST_MATCH: state_d = ST_READ;
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_DONE;
			ST_DONE:  if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands decoded from state
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.purge   = (state_q == ST_PURGE);
		cmd.match   = (state_q == ST_MATCH);
		cmd.eval    = (state_q == ST_EVAL);
		cmd.finish  = (state_q == ST_DONE) && stat.out_free;
	end

endmodule

`default_nettype wire

### sv/pcwrl_dpath.sv
// datapath: client table, purge, key match, window update and result register
// depends on pcwrl_pkg and pcwrl_out_if
`default_nettype none

module pcwrl_dpath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pcwrl_pkg::pcwrl_cfg_t  cfg,
	input  wire pcwrl_pkg::pcwrl_item_t item,
	input  wire pcwrl_pkg::pcwrl_cmd_t  cmd,
	output pcwrl_pkg::pcwrl_stat_t      stat,
	pcwrl_out_if.source                 out
);
	import pcwrl_pkg::*;

	// captured item
	logic              action_q;
	logic [KEY_W-1:0]  key_q;
	logic              loop_q;
	logic [TIME_W-1:0] now_q;

	// table: valid bits, keys and window starts in flops for parallel compare
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]         key_tab_q   [TABLE_ENTRIES];
	logic [TIME_W-1:0]        start_tab_q [TABLE_ENTRIES];
	logic [TIME_W-1:0]        last_purge_q;

	// count and start copies for indexed reads
	logic [CNT_W-1:0]  count_mem [TABLE_ENTRIES];
	logic [TIME_W-1:0] start_mem [TABLE_ENTRIES];
	logic [CNT_W-1:0]  count_rd_q;
	logic [TIME_W-1:0] start_rd_q;

	// match results
	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic             full_q;

	// evaluated window
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              refuse_q;

	// result register
	logic              out_valid_q;
	logic              allowed_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  made_q;
	logic [REM_W-1:0]  rem_q;
	logic [CFG_W-1:0]  reset_q;

	logic                     purge_due;
	logic [TIME_W-1:0]        limit2;
	logic [TABLE_ENTRIES-1:0] stale;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         free_idx;
	logic                     any_hit;

	logic              is_check;
	logic              do_write;
	logic [CNT_W-1:0]  base_count;
	logic [TIME_W-1:0] base_start;
	logic [TIME_W-1:0] base_elapsed;
	logic              expired;
	logic [CNT_W-1:0]  eff_count;
	logic [TIME_W-1:0] eff_start;
	logic [TIME_W-1:0] eff_elapsed;
	logic              eff_refuse;

	logic [REM_W-1:0] rem_v;
	logic [CFG_W-1:0] reset_v;
	logic [REM_W-1:0] loop_rem;

	assign is_check = (action_q == ACT_CHECK);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= item.action;
			key_q    <= item.client_key;
			loop_q   <= item.is_loopback;
			now_q    <= item.now_seconds;
		end
	end

	// purge test against every entry
	assign purge_due = is_check && ((now_q - last_purge_q) >= PURGE_INTERVAL);
	assign limit2    = TIME_W'({cfg.window_len, 1'b0});

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			stale[i] = valid_q[i] && ((now_q - start_tab_q[i]) >= limit2);
		end
	end

	// key compare against every entry
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_tab_q[i] == key_q);
		end
	end

	// lowest matching entry and lowest free entry
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	assign any_hit = |hit_vec;

	// valid bits and purge timestamp
	assign do_write = cmd.finish && is_check && !loop_q && (hit_q || !full_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			last_purge_q <= '0;
		end else if (cmd.purge && purge_due) begin
			valid_q      <= valid_q & ~stale;
			last_purge_q <= now_q;
		end else if (do_write) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	// match result
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_q  <= any_hit;
			full_q <= &valid_q;
			idx_q  <= any_hit ? hit_idx : free_idx;
		end
	end

	// table payload write-back
	always_ff @(posedge clk) begin
		if (do_write) begin
			key_tab_q[idx_q]   <= key_q;
			start_tab_q[idx_q] <= start_q;
		end
	end

	// count and start memories, registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			count_mem[idx_q] <= count_q;
			start_mem[idx_q] <= start_q;
		end
		count_rd_q <= count_mem[idx_q];
		start_rd_q <= start_mem[idx_q];
	end

	// window restart and limit test
	always_comb begin
		base_count   = hit_q ? count_rd_q : '0;
		base_start   = hit_q ? start_rd_q : now_q;
		base_elapsed = now_q - base_start;
		expired      = base_elapsed >= TIME_W'(cfg.window_len);
		if (is_check && expired) begin
			eff_count   = '0;
			eff_start   = now_q;
			eff_elapsed = '0;
		end else begin
			eff_count   = base_count;
			eff_start   = base_start;
			eff_elapsed = base_elapsed;
		end
		eff_refuse = eff_count >= cfg.max_requests;
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			refuse_q  <= eff_refuse;
			start_q   <= eff_start;
			elapsed_q <= eff_elapsed;
			if (is_check && !eff_refuse) begin
				count_q <= eff_count + CNT_W'(1);
			end else begin
				count_q <= eff_count;
			end
		end
	end

	// remaining and reset time from the updated window
	always_comb begin
		rem_v    = (count_q >= cfg.max_requests) ? '0
			: REM_W'(cfg.max_requests - count_q);
		reset_v  = (elapsed_q >= TIME_W'(cfg.window_len)) ? '0
			: cfg.window_len - elapsed_q[CFG_W-1:0];
		loop_rem = REM_W'(cfg.max_requests) * LOOPBACK_FACTOR;
	end

	// result register
	assign stat.out_free = !out_valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (loop_q) begin
				allowed_q <= 1'b1;
				status_q  <= STATUS_OK;
				made_q    <= '0;
				rem_q     <= loop_rem;
				reset_q   <= '0;
			end else if (!hit_q && !is_check) begin
				allowed_q <= 1'b1;
				status_q  <= STATUS_OK;
				made_q    <= '0;
				rem_q     <= REM_W'(cfg.max_requests);
				reset_q   <= cfg.window_len;
			end else if (!hit_q && full_q) begin
				allowed_q <= 1'b0;
				status_q  <= STATUS_TABLE_FULL;
				made_q    <= '0;
				rem_q     <= '0;
				reset_q   <= cfg.window_len;
			end else if (is_check && refuse_q) begin
				allowed_q <= 1'b0;
				status_q  <= STATUS_LIMITED;
				made_q    <= count_q;
				rem_q     <= '0;
				reset_q   <= reset_v;
			end else begin
				allowed_q <= 1'b1;
				status_q  <= STATUS_OK;
				made_q    <= count_q;
				rem_q     <= rem_v;
				reset_q   <= reset_v;
			end
		end
	end

	assign out.valid         = out_valid_q;
	assign out.allowed       = allowed_q;
	assign out.status        = status_q;
	assign out.made_count    = made_q;
	assign out.left_count    = rem_q;
	assign out.reset_seconds = reset_q;
	assign out.limit_value   = cfg.max_requests;

endmodule

`default_nettype wire

### sv/per_client_window_rate_limiter.sv
// a result is registered at the output after its transaction is accepted and the controller has
// walked its item through purge, key match, table read, window evaluation and result load;
// no new item is taken until the controller is back in idle
// a result waiting at the output delays the next item only if it is still held there
// reset clears the valid bits, purge time and registers at once; no clearing pass
`default_nettype none

module per_client_window_rate_limiter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pcwrl_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pcwrl_pkg::DATA_W-1:0] pwdata,
	output logic      [pcwrl_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	pcwrl_in_if.sink                          in,
	pcwrl_out_if.source                       out
);
	import pcwrl_pkg::*;

	pcwrl_cfg_t  cfg;
	pcwrl_item_t item;
	pcwrl_cmd_t  cmd;
	pcwrl_stat_t stat;

	// input payload bundle
	assign item.action      = in.action;
	assign item.client_key  = in.client_key;
	assign item.is_loopback = in.is_loopback;
	assign item.now_seconds = in.now_seconds;

	pcwrl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcwrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcwrl_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.out    (out)
	);

endmodule

`default_nettype wire
